// ===== sv/printf_integer_formatter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// printf integer formatter: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PRINTF_INTEGER_FORMATTER_UNIT_ASSERT_SVH
`define PRINTF_INTEGER_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication
`define PIFU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pifu assertion failed");

// next-cycle implication
`define PIFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pifu assertion failed");

`endif

// ===== sv/pifu_pkg.sv =====
// ----------------------------------------------------------------------------
// pifu_pkg
// Types, codes, character constants and helpers of the integer formatter.
// ----------------------------------------------------------------------------
package pifu_pkg;

  localparam int VALUE_W  = 64;
  localparam int BCD_DIGS = 20;
  localparam int BCD_W    = 4 * BCD_DIGS;
  localparam int LEN_W    = 7;

  localparam logic [5:0] PREC_CAP = 6'd60;

  // conversion kinds
  localparam logic [2:0] TYPE_SDEC = 3'd0;
  localparam logic [2:0] TYPE_UDEC = 3'd1;
  localparam logic [2:0] TYPE_OCT  = 3'd2;
  localparam logic [2:0] TYPE_HEXL = 3'd3;
  localparam logic [2:0] TYPE_HEXU = 3'd4;
  localparam logic [2:0] TYPE_BIN  = 3'd5;

  // length modifiers
  localparam logic [1:0] LM_INT   = 2'd0;
  localparam logic [1:0] LM_LONG  = 2'd1;
  localparam logic [1:0] LM_SHORT = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // digit store control
  typedef struct packed {
    logic push;
    logic pop;
  } dig_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== sv/pifu_bcd.sv =====
// ----------------------------------------------------------------------------
// pifu_bcd
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module pifu_bcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pifu_pkg::VALUE_W-1:0] value,
  output logic                       done,
  output logic [pifu_pkg::BCD_W-1:0]   bcd
);
  import pifu_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        bin  <= value;
        bcd  <= '0;
      end else if (busy) begin
        bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
        bin <= {bin[VALUE_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/pifu_digits.sv =====
// ----------------------------------------------------------------------------
// pifu_digits
// Digit shift line: digits enter at the top least significant first and
// leave from the top most significant first.
// ----------------------------------------------------------------------------
module pifu_digits #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  pifu_pkg::dig_ctl_t ctl,
  input  logic [3:0]         din,
  output logic [3:0]         top
);
  import pifu_pkg::*;

  logic [3:0] dig [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      dig[DEPTH-1] <= din;
    end else if (ctl.pop) begin
      for (int i = 1; i < DEPTH; i++) begin
        dig[i] <= dig[i-1];
      end
      dig[0] <= 4'd0;
    end
  end

  assign top = dig[DEPTH-1];

endmodule

// ===== sv/printf_integer_formatter_unit.sv =====
// Flow: decimal kinds first pass through the serial BCD converter; all kinds then
// extract one digit per cycle (D, at most 32), pass the PLAN and LAYOUT states and
// up to six phase steps; characters then leave at one per cycle while the output
// is not stalled (C, at most MAX_OUT). A new item is taken only once the block is idle.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit
// Formats one integer as printf integer conversion text, one char per result.
// ----------------------------------------------------------------------------
module printf_integer_formatter_unit #(
  parameter int MAX_DIGITS = 64,
  parameter int MAX_OUT    = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] value, [64] flag_minus, [65] flag_plus, [66] flag_space,
  // [67] flag_zero, [68] flag_hash, [75:69] field_width, [82:76] min_digits
  input  logic [87:0] s_tdata,
  // [2:0] req_type, [4:3] length_mod
  input  logic [4:0]  s_tuser,
  // result transaction
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_char
  output logic [7:0]  m_tdata,
  // [0] char_valid
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);
  import pifu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_EXTRACT, ST_PLAN, ST_LAYOUT, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGN, PH_PREF, PH_ZPAD, PH_PRECZ, PH_DIGS, PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {RAD_2, RAD_8, RAD_10, RAD_16} radix_t;

  localparam logic [LEN_W-1:0] OUT_CAP   = LEN_W'(MAX_OUT);
  localparam logic [LEN_W-1:0] DIG_LIMIT = LEN_W'(MAX_DIGITS);

  state_t             state;
  phase_t             phase;
  radix_t             radix;
  logic               upper;
  logic               has_sign;
  logic [7:0]         sign_ch;
  logic               f_minus;
  logic               f_zero;
  logic               f_hash;
  logic [LEN_W-1:0]   width;
  logic               prec_given;
  logic [5:0]         prec;
  logic               mag_nz;
  logic [BCD_W-1:0]   work;
  logic [LEN_W-1:0]   count;
  logic [1:0]         plen;
  logic [LEN_W-1:0]   pad;
  logic [LEN_W-1:0]   zeros;
  logic               zpad;
  logic [LEN_W-1:0]   run;
  logic [LEN_W-1:0]   emitted;
  logic [LEN_W-1:0]   n_out;

  // ---------------------------------------------------------------- accept
  logic               accept;
  logic [2:0]         in_type;
  logic [1:0]         in_lm;
  logic [VALUE_W-1:0] in_val;
  logic [VALUE_W-1:0] in_x;
  logic [VALUE_W-1:0] in_mag;
  logic [6:0]         in_praw;
  logic [5:0]         in_prec;
  logic               in_given;
  logic [LEN_W-1:0]   in_width;
  logic               in_skip;
  logic               in_dec;
  radix_t             in_radix;
  logic               in_has_sign;
  logic [7:0]         in_sign_ch;

  assign accept   = s_tvalid && s_tready;
  assign in_type  = s_tuser[2:0];
  assign in_lm    = s_tuser[4:3];
  assign in_val   = s_tdata[63:0];
  assign in_praw  = s_tdata[82:76];
  assign in_given = !in_praw[6];
  assign in_prec  = (in_praw[5:0] > PREC_CAP) ? PREC_CAP : in_praw[5:0];
  assign in_width = (s_tdata[75:69] > OUT_CAP) ? OUT_CAP : s_tdata[75:69];

  always_comb begin
    // sign-extended value for the signed kind
    case (in_lm)
      LM_LONG:  in_x = in_val;
      LM_SHORT: in_x = {{48{in_val[15]}}, in_val[15:0]};
      default:  in_x = {{32{in_val[31]}}, in_val[31:0]};
    endcase

    in_has_sign = 1'b0;
    in_sign_ch  = CH_SPACE;
    case (in_type) inside
      TYPE_SDEC: begin
        in_radix = RAD_10;
        if (in_x[63]) begin
          in_mag      = ~in_x + 1'b1;
          in_has_sign = 1'b1;
          in_sign_ch  = CH_MINUS;
        end else begin
          in_mag      = in_x;
          in_has_sign = s_tdata[65] || s_tdata[66];
          in_sign_ch  = s_tdata[65] ? CH_PLUS : CH_SPACE;
        end
      end
      TYPE_BIN: begin
        in_radix = RAD_2;
        in_mag   = {32'd0, in_val[31:0]};
      end
      default: begin
        if (in_type == TYPE_UDEC) begin
          in_radix = RAD_10;
        end else if (in_type == TYPE_OCT) begin
          in_radix = RAD_8;
        end else begin
          in_radix = RAD_16;
        end
        case (in_lm)
          LM_LONG:  in_mag = in_val;
          LM_SHORT: in_mag = {48'd0, in_val[15:0]};
          default:  in_mag = {32'd0, in_val[31:0]};
        endcase
      end
    endcase

    in_dec  = (in_radix == RAD_10);
    // zero with precision zero prints no digits
    in_skip = (in_mag == '0) && in_given && (in_prec == 6'd0);
  end

  // ------------------------------------------------------------ BCD unit
  logic               bcd_start;
  logic               bcd_done;
  logic [BCD_W-1:0]   bcd_val;

  assign bcd_start = accept && (in_type <= TYPE_BIN) && in_dec && !in_skip;

  pifu_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .value (in_mag),
    .done  (bcd_done),
    .bcd   (bcd_val)
  );

  // ----------------------------------------------------- digit extraction
  logic [3:0]         ext_digit;
  logic [BCD_W-1:0]   ext_work;

  always_comb begin
    case (radix)
      RAD_2: begin
        ext_digit = {3'd0, work[0]};
        ext_work  = work >> 1;
      end
      RAD_8: begin
        ext_digit = {1'b0, work[2:0]};
        ext_work  = work >> 3;
      end
      default: begin
        ext_digit = work[3:0];
        ext_work  = work >> 4;
      end
    endcase
  end

  // octal with hash and no digits prints a single '0'
  logic               oct_fix;
  assign oct_fix = f_hash && (radix == RAD_8) && (count == '0);

  // ---------------------------------------------------------- digit store
  dig_ctl_t           dig_ctl;
  logic [3:0]         dig_din;
  logic [3:0]         dig_top;
  logic               emit_fire;
  logic               take;
  logic               out_load;

  assign take      = !m_tvalid || m_tready;
  assign emit_fire = (state == ST_EMIT) && (n_out != '0) && (emitted != n_out) &&
                     (run != '0) && take;
  // output register loads a character or the empty-output marker
  assign out_load  = emit_fire || ((state == ST_EMIT) && (n_out == '0) && take);

  assign dig_ctl.push = ((state == ST_EXTRACT) && (count < DIG_LIMIT)) ||
                        ((state == ST_PLAN) && oct_fix);
  assign dig_ctl.pop  = emit_fire && (phase == PH_DIGS);
  assign dig_din      = (state == ST_EXTRACT) ? ext_digit : 4'd0;

  pifu_digits #(.DEPTH(MAX_DIGITS)) u_digits (
    .clk (clk),
    .ctl (dig_ctl),
    .din (dig_din),
    .top (dig_top)
  );

  // --------------------------------------------------------------- layout
  logic [LEN_W-1:0]   lay_zeros;
  logic [LEN_W-1:0]   lay_total;
  logic [LEN_W-1:0]   lay_pad;
  logic [LEN_W-1:0]   lay_full;
  logic               lay_zpad;

  always_comb begin
    lay_zeros = (prec_given && ({1'b0, prec} > count)) ? {1'b0, prec} - count : '0;
    lay_total = count + lay_zeros + LEN_W'(plen) + LEN_W'(has_sign);
    lay_pad   = (width > lay_total) ? width - lay_total : '0;
    lay_full  = (width > lay_total) ? width : lay_total;
    lay_zpad  = f_zero && !f_minus && !prec_given;
  end

  // ---------------------------------------------------- phase sequencing
  phase_t             nxt_phase;
  logic [LEN_W-1:0]   nxt_run;
  logic [7:0]         emit_ch;

  always_comb begin
    case (phase)
      PH_LEAD: begin
        nxt_phase = PH_SIGN;
        nxt_run   = LEN_W'(has_sign);
      end
      PH_SIGN: begin
        nxt_phase = PH_PREF;
        nxt_run   = LEN_W'(plen);
      end
      PH_PREF: begin
        nxt_phase = PH_ZPAD;
        nxt_run   = zpad ? pad : '0;
      end
      PH_ZPAD: begin
        nxt_phase = PH_PRECZ;
        nxt_run   = zeros;
      end
      PH_PRECZ: begin
        nxt_phase = PH_DIGS;
        nxt_run   = count;
      end
      PH_DIGS: begin
        nxt_phase = PH_TRAIL;
        nxt_run   = f_minus ? pad : '0;
      end
      default: begin
        nxt_phase = PH_TRAIL;
        nxt_run   = '0;
      end
    endcase

    case (phase)
      PH_SIGN:  emit_ch = sign_ch;
      // "0" or "0x": the x goes out when one prefix char remains of two
      PH_PREF:  emit_ch = ((run == LEN_W'(1)) && (plen == 2'd2)) ?
                          (upper ? CH_X_UP : CH_X_LO) : CH_ZERO;
      PH_ZPAD:  emit_ch = CH_ZERO;
      PH_PRECZ: emit_ch = CH_ZERO;
      PH_DIGS:  emit_ch = digit_char(dig_top, upper);
      default:  emit_ch = CH_SPACE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_LEAD;
      m_tvalid <= 1'b0;
      count    <= '0;
      emitted  <= '0;
      n_out    <= '0;
      run      <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            radix      <= in_radix;
            upper      <= (in_type == TYPE_HEXU);
            has_sign   <= in_has_sign;
            sign_ch    <= in_sign_ch;
            f_minus    <= s_tdata[64];
            f_zero     <= s_tdata[67];
            f_hash     <= s_tdata[68];
            width      <= in_width;
            prec_given <= in_given;
            prec       <= in_prec;
            mag_nz     <= (in_mag != '0);
            work       <= {{(BCD_W - VALUE_W){1'b0}}, in_mag};
            count      <= '0;
            plen       <= 2'd0;
            if (in_type > TYPE_BIN) begin
              // unused kind: empty output
              n_out <= '0;
              state <= ST_EMIT;
            end else if (in_skip) begin
              state <= ST_PLAN;
            end else if (in_dec) begin
              state <= ST_CONV;
            end else begin
              state <= ST_EXTRACT;
            end
          end
        end

        ST_CONV: begin
          if (bcd_done) begin
            work  <= bcd_val;
            state <= ST_EXTRACT;
          end
        end

        ST_EXTRACT: begin
          // one digit a cycle, least significant first, at least one digit
          work <= ext_work;
          if (count < DIG_LIMIT) begin
            count <= count + 1'b1;
          end
          if (ext_work == '0) begin
            state <= ST_PLAN;
          end
        end

        ST_PLAN: begin
          if (f_hash && (radix == RAD_16) && mag_nz) begin
            plen <= 2'd2;
          end
          if (oct_fix) begin
            count <= LEN_W'(1);
          end else if (f_hash && (radix == RAD_8) && mag_nz &&
                       (!prec_given || ({1'b0, prec} <= count))) begin
            plen <= 2'd1;
          end
          state <= ST_LAYOUT;
        end

        ST_LAYOUT: begin
          zeros   <= lay_zeros;
          pad     <= lay_pad;
          zpad    <= lay_zpad;
          n_out   <= (lay_full > OUT_CAP) ? OUT_CAP : lay_full;
          emitted <= '0;
          phase   <= PH_LEAD;
          run     <= (!f_minus && !lay_zpad) ? lay_pad : '0;
          state   <= ST_EMIT;
        end

        ST_EMIT: begin
          if (n_out == '0) begin
            if (take) begin
              m_tdata  <= CH_NUL;
              m_tuser  <= 1'b0;
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else if (emitted == n_out) begin
            // all text out, or the output cap reached
            state <= ST_IDLE;
          end else if (run == '0) begin
            phase <= nxt_phase;
            run   <= nxt_run;
          end else if (take) begin
            m_tdata  <= emit_ch;
            m_tuser  <= 1'b1;
            m_tlast  <= (emitted + 1'b1 == n_out);
            run      <= run - 1'b1;
            emitted  <= emitted + 1'b1;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pifu_checker.sv =====
// ----------------------------------------------------------------------------
// pifu_checker
// Port-level checks of the integer formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "printf_integer_formatter_unit_assert.svh"

module pifu_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser,
  input logic       m_tlast
);

  // a stalled result holds
  `PIFU_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // one input transaction at a time: ready drops after an accept
  `PIFU_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // the empty-output result is a lone, last, zero character
  `PIFU_ASSERT_NOW(a_empty_last, clk, rst, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 8'h00))

  // real characters are printable ASCII of the formatter's alphabet
  `PIFU_ASSERT_NOW(a_printable, clk, rst, m_tvalid && m_tuser[0], (m_tdata >= 8'h20) && (m_tdata <= 8'h7a))

endmodule

bind printf_integer_formatter_unit pifu_checker u_pifu_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: printf integer formatter regression
// Streams format requests into the formatter and checks every emitted
// character against a behavioral formatter kept in the bench. A directed
// set of edge cases comes first, then constrained-random requests under
// varying backpressure on both stream interfaces.
// ----------------------------------------------------------------------------
module tb_top;
  import pifu_pkg::*;

  // codes the package leaves unnamed: unused kinds and length modifier
  localparam logic [2:0] TYPE_UNUSED_A = 3'd6;
  localparam logic [2:0] TYPE_UNUSED_B = 3'd7;
  localparam logic [1:0] LM_UNUSED     = 2'd3;

  // precision field: any negative value means "not given"
  localparam logic [6:0] PREC_NONE     = 7'h7F;
  localparam logic [6:0] PREC_MOST_NEG = 7'h40;

  // flag set bits used by the directed list
  localparam logic [4:0] F_MINUS = 5'b00001;
  localparam logic [4:0] F_PLUS  = 5'b00010;
  localparam logic [4:0] F_SPACE = 5'b00100;
  localparam logic [4:0] F_ZERO  = 5'b01000;
  localparam logic [4:0] F_HASH  = 5'b10000;

  localparam int N_RANDOM   = 330;
  localparam int PLAN_TOTAL = N_RANDOM + 25;

  // One long output stall while the sender keeps offering requests.
  localparam int HOLD_AT  = 200;
  localparam int HOLD_LEN = 400;

  // Worst quiet stretch of a correct run: the output hold plus one full decimal
  // item plus random gaps. Several times that is allowed before the run is
  // called hung.
  localparam int WATCHDOG    = 4000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  len_mod;
    logic [63:0] value;
    logic        minus;
    logic        plus;
    logic        space;
    logic        zero;
    logic        hash;
    logic [6:0]  width;
    logic [6:0]  prec;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } text_char_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata  = '0;
  logic [4:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  printf_integer_formatter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  fmt_req_t   pending_reqs [$];   // requests not yet offered
  text_char_t due_chars [$];      // characters predicted, not yet seen
  fmt_req_t   offer = '0;         // request currently on the input bus

  logic s_fire    = 1'b0;         // input transaction at the last rising edge
  int   reqs_taken = 0;
  int   chars_seen = 0;
  int   empty_seen = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   n_directed = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  // idling schedule by progress: sender 7 / receiver 50 percent, then the
  // reverse, then both sides at full rate
  wire [1:0] idle_phase = (reqs_taken < PLAN_TOTAL / 3)     ? 2'd0 :
                          (reqs_taken < 2 * PLAN_TOTAL / 3) ? 2'd1 : 2'd2;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Formatter prediction: narrow, split into digits, lay out the fields in
  // printf order and clip the text to 64 characters.
  // --------------------------------------------------------------------------
  function automatic void render_text(input fmt_req_t r);
    logic [63:0] x, mag, m, base, d;
    logic [3:0]  digs [0:63];
    logic [7:0]  sgn;
    logic [7:0]  pre [0:1];
    logic [7:0]  c;
    logic [7:0]  text [$];
    logic        upper, zpad;
    int          n_dig, plen, zeros, total, pad, wid, prec, n, i;
    text_char_t  tc;

    upper = 1'b0;
    sgn   = CH_NUL;
    plen  = 0;
    n_dig = 0;
    zeros = 0;
    pad   = 0;
    base  = 64'd10;
    mag   = '0;
    wid   = (r.width > 7'd64) ? 64 : int'(r.width);
    if (r.prec[6]) begin
      prec = -1;
    end else begin
      prec = (r.prec > 7'd60) ? 60 : int'(r.prec);
    end

    // unused kinds produce only the empty marker
    if (r.kind > TYPE_BIN) begin
      due_chars.push_back('{ch: CH_NUL, valid: 1'b0, last: 1'b1});
      return;
    end

    if (r.kind == TYPE_SDEC) begin
      if (r.len_mod == LM_LONG) begin
        x = r.value;
      end else if (r.len_mod == LM_SHORT) begin
        x = {{48{r.value[15]}}, r.value[15:0]};
      end else begin
        x = {{32{r.value[31]}}, r.value[31:0]};
      end
      if (x[63]) begin
        sgn = CH_MINUS;
        mag = 64'd0 - x;
      end else begin
        mag = x;
        if (r.plus) begin
          sgn = CH_PLUS;
        end else if (r.space) begin
          sgn = CH_SPACE;
        end
      end
    end else if (r.kind == TYPE_BIN) begin
      base = 64'd2;
      mag  = {32'd0, r.value[31:0]};
    end else begin
      base  = (r.kind == TYPE_UDEC) ? 64'd10 : (r.kind == TYPE_OCT) ? 64'd8 : 64'd16;
      upper = (r.kind == TYPE_HEXU);
      if (r.len_mod == LM_LONG) begin
        mag = r.value;
      end else if (r.len_mod == LM_SHORT) begin
        mag = {48'd0, r.value[15:0]};
      end else begin
        mag = {32'd0, r.value[31:0]};
      end
    end

    // zero with precision 0 has no digits at all
    if (!(mag == 64'd0 && prec == 0)) begin
      m = mag;
      do begin
        d = m % base;
        digs[n_dig] = d[3:0];
        n_dig++;
        m = m / base;
      end while (m != 64'd0);
    end

    if (r.hash && base == 64'd16 && mag != 64'd0) begin
      pre[0] = CH_ZERO;
      pre[1] = upper ? CH_X_UP : CH_X_LO;
      plen   = 2;
    end
    // octal alternate form: a leading zero unless precision already gives one
    if (r.hash && base == 64'd8) begin
      if (n_dig == 0) begin
        digs[0] = 4'd0;
        n_dig   = 1;
      end else if (mag != 64'd0 && prec <= n_dig) begin
        pre[0] = CH_ZERO;
        plen   = 1;
      end
    end

    if (prec > n_dig) zeros = prec - n_dig;
    total = n_dig + zeros + plen + ((sgn != CH_NUL) ? 1 : 0);
    if (wid > total) pad = wid - total;
    zpad = r.zero && !r.minus && prec < 0;

    if (!r.minus && !zpad) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);
    if (sgn != CH_NUL) text.push_back(sgn);
    for (i = 0; i < plen; i++) text.push_back(pre[i]);
    if (!r.minus && zpad) for (i = 0; i < pad; i++) text.push_back(CH_ZERO);
    for (i = 0; i < zeros; i++) text.push_back(CH_ZERO);
    for (i = n_dig - 1; i >= 0; i--) begin
      if (digs[i] < 4'd10) begin
        c = CH_ZERO + {4'd0, digs[i]};
      end else begin
        c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, digs[i]} - 8'd10;
      end
      text.push_back(c);
    end
    if (r.minus) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);

    n = (text.size() > 64) ? 64 : text.size();
    if (n == 0) begin
      due_chars.push_back('{ch: CH_NUL, valid: 1'b0, last: 1'b1});
    end else begin
      for (i = 0; i < n; i++) begin
        tc.ch    = text[i];
        tc.valid = 1'b1;
        tc.last  = (i == n - 1);
        due_chars.push_back(tc);
      end
    end
  endfunction

  task automatic add_req(input logic [2:0] kind, input logic [1:0] lm,
                         input logic [63:0] value, input logic [4:0] flags,
                         input logic [6:0] width, input logic [6:0] prec);
    fmt_req_t r;
    r.kind    = kind;
    r.len_mod = lm;
    r.value   = value;
    r.minus   = flags[0];
    r.plus    = flags[1];
    r.space   = flags[2];
    r.zero    = flags[3];
    r.hash    = flags[4];
    r.width   = width;
    r.prec    = prec;
    pending_reqs.push_back(r);
  endtask

  // Random request: mostly legal kinds and sizes with values around the
  // narrowing boundaries, plus a few unused codes and oversized fields.
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    int       pick;

    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.kind = ($urandom_range(0, 1) != 0) ? TYPE_UNUSED_A : TYPE_UNUSED_B;
    end else begin
      r.kind = 3'($urandom_range(TYPE_SDEC, TYPE_BIN));
    end
    r.len_mod = ($urandom_range(0, 99) < 5) ? LM_UNUSED : 2'($urandom_range(0, 2));

    case ($urandom_range(0, 6))
      0: r.value = 64'd0;
      1: r.value = 64'($urandom_range(0, 999));
      2: r.value = {$urandom, $urandom};
      3: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: r.value = 64'd0 - 64'($urandom_range(1, 500));
      5: r.value = {$urandom, $urandom} | (64'd1 << (($urandom_range(0, 2) == 0) ? 15 :
                   ($urandom_range(0, 1) == 0) ? 31 : 63));
      default: begin
        case ($urandom_range(0, 3))
          0: r.value = 64'h0000_0000_0000_7FFF;
          1: r.value = 64'h0000_0000_8000_0000;
          2: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
          default: r.value = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase

    {r.hash, r.zero, r.space, r.plus, r.minus} = 5'($urandom_range(0, 31));

    pick = $urandom_range(0, 99);
    if (pick < 80)      r.width = 7'($urandom_range(0, 24));
    else if (pick < 95) r.width = 7'($urandom_range(25, 64));
    else                r.width = 7'($urandom_range(65, 127));

    pick = $urandom_range(0, 99);
    if (pick < 40)      r.prec = 7'($urandom_range(64, 127));
    else if (pick < 85) r.prec = 7'($urandom_range(0, 12));
    else if (pick < 95) r.prec = 7'($urandom_range(13, 60));
    else                r.prec = 7'($urandom_range(61, 63));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: changes the bus at the falling edge. A slot is free when
  // nothing is offered or the offered transaction was taken at the last edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    fmt_req_t nxt;
    int       idle_pct;
    idle_pct = (idle_phase == 2'd0) ? 7 : (idle_phase == 2'd1) ? 50 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pending_reqs.pop_front();
        offer    <= nxt;
        s_tvalid <= 1'b1;
        // tdata: value, minus, plus, space, zero, hash, width, precision
        s_tdata  <= {5'd0, nxt.prec, nxt.width, nxt.hash, nxt.zero, nxt.space,
                     nxt.plus, nxt.minus, nxt.value};
        // tuser: kind, length modifier
        s_tuser  <= {nxt.len_mod, nxt.kind};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: random stalls per phase, and one long hold counted here
  // while the sender keeps the input busy, so the block backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : char_sink
    int idle_pct;
    idle_pct = (idle_phase == 2'd0) ? 50 : (idle_phase == 2'd1) ? 7 : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && reqs_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both interfaces at the rising edge. Each input
  // transaction is turned into its predicted text; each output transaction
  // is checked against the oldest predicted character.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    text_char_t want;
    logic       in_fire, out_fire;
    in_fire  = !rst && s_tvalid && s_tready;
    out_fire = !rst && m_tvalid && m_tready;
    s_fire <= in_fire;

    if (out_fire) begin
      chars_seen++;
      if (!m_tuser[0]) empty_seen++;
      if (due_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char transaction: char %h valid %b last %b",
                   m_tdata, m_tuser[0], m_tlast);
      end else begin
        want = due_chars.pop_front();
        if (m_tdata !== want.ch || m_tuser[0] !== want.valid || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char %0d mismatch: got char %h valid %b last %b, want %h %b %b",
                     chars_seen, m_tdata, m_tuser[0], m_tlast,
                     want.ch, want.valid, want.last);
        end
      end
    end

    if (in_fire) begin
      reqs_taken++;
      render_text(offer);
    end

    // hang detection: count edges with no transaction on either side
    if (rst || in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles, %0d chars outstanding",
                 WATCHDOG, due_chars.size());
        $display("printf_integer_formatter_unit regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed cases, a full drain, random requests, drain,
  // then a quiet tail to catch stray output.
  // --------------------------------------------------------------------------
  initial begin : sequence_ctl
    int k;

    // zero with default everything, the most negative values per size and the largest short
    add_req(TYPE_SDEC, LM_INT,   64'd0,                 5'd0,           7'd0,  PREC_NONE);
    add_req(TYPE_SDEC, LM_INT,   64'h0000_0000_8000_0000, 5'd0,         7'd0,  PREC_NONE);
    add_req(TYPE_SDEC, LM_LONG,  64'h8000_0000_0000_0000, 5'd0,         7'd25, PREC_NONE);
    add_req(TYPE_SDEC, LM_SHORT, 64'hFFFF_FFFF_FFFF_8000, F_PLUS,       7'd0,  PREC_NONE);
    add_req(TYPE_SDEC, LM_SHORT, 64'h0000_0000_0000_7FFF, F_PLUS,       7'd0,  PREC_NONE);
    // plus wins over space; space alone, left-justified
    add_req(TYPE_SDEC, LM_INT,   64'd42, F_PLUS | F_SPACE,              7'd6,  PREC_NONE);
    add_req(TYPE_SDEC, LM_INT,   64'd42, F_SPACE | F_MINUS,             7'd8,  PREC_NONE);
    add_req(TYPE_UDEC, LM_LONG,  64'hFFFF_FFFF_FFFF_FFFF, F_PLUS,       7'd0,  PREC_NONE);
    // octal alternate form: prefix, zero with precision 0, precision already zero-led
    add_req(TYPE_OCT,  LM_LONG,  64'hFFFF_FFFF_FFFF_FFFF, F_HASH,       7'd0,  PREC_NONE);
    add_req(TYPE_OCT,  LM_INT,   64'd0,  F_HASH,                        7'd0,  7'd0);
    add_req(TYPE_OCT,  LM_INT,   64'd8,  F_HASH,                        7'd0,  7'd5);
    // hex prefixes with zero padding and left justification; hash on zero
    add_req(TYPE_HEXL, LM_INT,   64'h1234_5678_DEAD_BEEF, F_HASH | F_ZERO, 7'd14, PREC_NONE);
    add_req(TYPE_HEXU, LM_LONG,  64'hFFFF_FFFF_FFFF_FFFF, F_HASH | F_MINUS, 7'd20, PREC_NONE);
    add_req(TYPE_HEXL, LM_SHORT, 64'hABCD_0000,           F_HASH,       7'd0,  PREC_NONE);
    // binary ignores the length modifier and keeps 32 bits
    add_req(TYPE_BIN,  LM_LONG,  64'hFFFF_FFFF_FFFF_FFFF, F_ZERO,       7'd64, PREC_NONE);
    // no digits at all: empty output, and spaces only
    add_req(TYPE_SDEC, LM_INT,   64'd0,  5'd0,                          7'd0,  7'd0);
    add_req(TYPE_UDEC, LM_INT,   64'd0,  F_MINUS,                       7'd5,  7'd0);
    add_req(TYPE_UNUSED_A, LM_INT, 64'd123, 5'd0,                       7'd10, PREC_NONE);
    add_req(TYPE_UNUSED_B, LM_LONG, 64'hFFFF_FFFF_FFFF_FFFF, 5'b11111, 7'd127, 7'd63);
    // unused length modifier behaves as int
    add_req(TYPE_SDEC, LM_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0,        7'd0,  PREC_NONE);
    // width and precision above their caps, most negative precision
    add_req(TYPE_UDEC, LM_INT,   64'd7,  5'd0,                          7'd127, PREC_NONE);
    add_req(TYPE_SDEC, LM_LONG,  64'hFFFF_FFFF_FFFF_FFFB, 5'd0,         7'd64, 7'd63);
    add_req(TYPE_HEXU, LM_INT,   64'h0000_0000_0000_00AF, F_HASH,       7'd0,  7'd60);
    add_req(TYPE_SDEC, LM_INT,   64'd77, F_ZERO,                        7'd9,  PREC_MOST_NEG);
    // zero flag is ignored with a precision
    add_req(TYPE_SDEC, LM_INT,   64'd7,  F_ZERO,                        7'd6,  7'd3);
    n_directed = pending_reqs.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender pause: nothing more is queued until every directed char is back
    while (pending_reqs.size() != 0 || s_tvalid || due_chars.size() != 0) @(negedge clk);

    for (k = 0; k < N_RANDOM; k++) pending_reqs.push_back(random_req());

    while (pending_reqs.size() != 0 || s_tvalid || due_chars.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (due_chars.size() != 0) begin
      mismatches += due_chars.size();
      $display("%0d predicted chars never arrived", due_chars.size());
    end

    $display("covered %0d format requests (%0d directed) over all kinds, sizes and flags,",
             reqs_taken, n_directed);
    $display("checked %0d char transactions (%0d empty) with a %0d-cycle output hold, %0d errors",
             chars_seen, empty_seen, HOLD_LEN, mismatches);
    if (mismatches == 0) begin
      $display("printf_integer_formatter_unit regression: pass");
    end else begin
      $display("printf_integer_formatter_unit regression: fail");
    end
    $finish;
  end

endmodule
